@@ rtl/core/tabl_pkg.sv @@
// Shared types and constants for the three-axis biquad lowpass.
// Used by tabl_coef_regs, tabl_lane and three_axis_biquad_lowpass.
`default_nettype none

package tabl_pkg;

  localparam int LANES          = 3;
  localparam int COEF_FRAC_BITS = 22;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 24;
  localparam int OUT_W     = 24;
  localparam int OUT_FRAC  = 8;
  localparam int NCOEF     = 5;
  localparam int CFG_IDX_W = 3;

  localparam int FF_PROD_W = COEF_W + SAMPLE_W;
  localparam int FF_W      = FF_PROD_W + 2;
  localparam int FB_PROD_W = COEF_W + OUT_W;
  localparam int ACC_W     = FF_W + OUT_FRAC + 2;

  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  localparam logic signed [COEF_W-1:0] A1_RESET = -24'sd6188693;
  localparam logic signed [COEF_W-1:0] A2_RESET = 24'sd2461638;
  localparam logic signed [COEF_W-1:0] B0_RESET = 24'sd117021;
  localparam logic signed [COEF_W-1:0] B1_RESET = 24'sd233623;
  localparam logic signed [COEF_W-1:0] B2_RESET = 24'sd117021;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_A1 = 3'd0,
    REG_A2 = 3'd1,
    REG_B0 = 3'd2,
    REG_B1 = 3'd3,
    REG_B2 = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
  } coef_t;

  typedef struct packed {
    logic load_in;
    logic load_out;
  } lane_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/tabl_coef_regs.sv @@
// Coefficient register file for the biquad lanes, written over the config channel.
// Depends on tabl_pkg.
`default_nettype none

module tabl_coef_regs (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  input  wire logic [tabl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tabl_pkg::COEF_W-1:0]     cfg_data,
  output tabl_pkg::coef_t                      coef
);

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.a1 <= tabl_pkg::A1_RESET;
      coef.a2 <= tabl_pkg::A2_RESET;
      coef.b0 <= tabl_pkg::B0_RESET;
      coef.b1 <= tabl_pkg::B1_RESET;
      coef.b2 <= tabl_pkg::B2_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tabl_pkg::REG_A1: coef.a1 <= cfg_data;
        tabl_pkg::REG_A2: coef.a2 <= cfg_data;
        tabl_pkg::REG_B0: coef.b0 <= cfg_data;
        tabl_pkg::REG_B1: coef.b1 <= cfg_data;
        tabl_pkg::REG_B2: coef.b2 <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/tabl_lane.sv @@
// One biquad lane: feedforward stage, then feedback, rounding and saturation.
// Depends on tabl_pkg; control comes from the top level pipeline.
`default_nettype none

module tabl_lane (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire tabl_pkg::lane_ctrl_t                ctrl,
  input  wire tabl_pkg::coef_t                     coef,
  input  wire logic signed [tabl_pkg::SAMPLE_W-1:0] sample,
  output logic signed [tabl_pkg::OUT_W-1:0]        filtered,
  output logic                                     clip
);

  logic signed [tabl_pkg::SAMPLE_W-1:0]  x1;
  logic signed [tabl_pkg::SAMPLE_W-1:0]  x2;
  logic signed [tabl_pkg::OUT_W-1:0]     y1;
  logic signed [tabl_pkg::OUT_W-1:0]     y2;
  logic signed [tabl_pkg::FF_W-1:0]      ff;
  logic signed [tabl_pkg::FF_W-1:0]      ff_next;
  logic signed [tabl_pkg::FF_PROD_W-1:0] pb0;
  logic signed [tabl_pkg::FF_PROD_W-1:0] pb1;
  logic signed [tabl_pkg::FF_PROD_W-1:0] pb2;
  logic signed [tabl_pkg::FB_PROD_W-1:0] pa1;
  logic signed [tabl_pkg::FB_PROD_W-1:0] pa2;
  logic signed [tabl_pkg::ACC_W-1:0]     acc;
  logic signed [tabl_pkg::ACC_W-1:0]     q;
  logic                                  fits;
  logic signed [tabl_pkg::OUT_W-1:0]     y_next;

  // stage 1: feedforward sum from the new sample and input history
  assign pb0 = $signed(coef.b0) * sample;
  assign pb1 = $signed(coef.b1) * x1;
  assign pb2 = $signed(coef.b2) * x2;

  assign ff_next = {{2{pb0[tabl_pkg::FF_PROD_W-1]}}, pb0}
                 + {{2{pb1[tabl_pkg::FF_PROD_W-1]}}, pb1}
                 + {{2{pb2[tabl_pkg::FF_PROD_W-1]}}, pb2};

  // stage 2: feedback on the previous outputs
  assign pa1 = $signed(coef.a1) * y1;
  assign pa2 = $signed(coef.a2) * y2;

  always_comb begin
    acc = {{2{ff[tabl_pkg::FF_W-1]}}, ff, {tabl_pkg::OUT_FRAC{1'b0}}}
        - {{(tabl_pkg::ACC_W - tabl_pkg::FB_PROD_W){pa1[tabl_pkg::FB_PROD_W-1]}}, pa1}
        - {{(tabl_pkg::ACC_W - tabl_pkg::FB_PROD_W){pa2[tabl_pkg::FB_PROD_W-1]}}, pa2};
    q = (acc + $signed(tabl_pkg::ROUND_HALF)) >>> tabl_pkg::COEF_FRAC_BITS;
    fits = (q[tabl_pkg::ACC_W-1:tabl_pkg::OUT_W-1]
            == {(tabl_pkg::ACC_W - tabl_pkg::OUT_W + 1){q[tabl_pkg::ACC_W-1]}});
    if (fits) begin
      y_next = q[tabl_pkg::OUT_W-1:0];
    end else if (q[tabl_pkg::ACC_W-1]) begin
      y_next = tabl_pkg::OUT_MIN;
    end else begin
      y_next = tabl_pkg::OUT_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x1 <= '0;
      x2 <= '0;
      y1 <= '0;
      y2 <= '0;
    end else begin
      if (ctrl.load_in) begin
        x1 <= sample;
        x2 <= x1;
      end
      if (ctrl.load_out) begin
        y1 <= y_next;
        y2 <= y1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      ff <= ff_next;
    end
    if (ctrl.load_out) begin
      clip <= !fits;
    end
  end

  // newest output doubles as the output register
  assign filtered = y1;

endmodule

`default_nettype wire

@@ rtl/core/three_axis_biquad_lowpass.sv @@
// Top level: three parallel biquad lanes, handshake pipeline and result merge.
// Depends on tabl_pkg, tabl_coef_regs and tabl_lane.
//
//  channel  dir  handshake             payload
//  s_*      in   s_tvalid/s_tready     s_tdata: sample_x, sample_y, sample_z
//  m_*      out  m_tvalid/m_tready     m_tdata: filtered_x/y/z; m_tuser: clipped
//  cfg_*    in   cfg_valid/cfg_ready   cfg_index, cfg_data (coefficient write)
//
// One request per cycle while the output is not stalled; a result passes stage one, then the output register.
// Stage one forms the feedforward sum, stage two the feedback terms, rounding
// and saturation; the feedback loop through stage two sets the rate.
// Synchronous reset restores the default coefficients and clears all history.
// A stalled result holds the output register; stage one takes one more request
// only while it is empty.
`default_nettype none

module three_axis_biquad_lowpass (
  input  wire logic                                         clk,
  input  wire logic                                         rst,
  input  wire logic                                         s_tvalid,
  output logic                                              s_tready,
  // sample_x [15:0], sample_y [31:16], sample_z [47:32]
  input  wire logic [tabl_pkg::LANES*tabl_pkg::SAMPLE_W-1:0] s_tdata,
  output logic                                              m_tvalid,
  input  wire logic                                         m_tready,
  // filtered_x [23:0], filtered_y [47:24], filtered_z [71:48]
  output logic [tabl_pkg::LANES*tabl_pkg::OUT_W-1:0]        m_tdata,
  // clipped [0]
  output logic                                              m_tuser,
  input  wire logic                                         cfg_valid,
  output logic                                              cfg_ready,
  input  wire logic [tabl_pkg::CFG_IDX_W-1:0]               cfg_index,
  input  wire logic [tabl_pkg::COEF_W-1:0]                  cfg_data
);

  tabl_pkg::coef_t      coef;
  tabl_pkg::lane_ctrl_t ctrl;
  logic                 s1_valid;
  logic                 out_valid;
  logic                 adv1;
  logic                 adv2;
  logic [tabl_pkg::LANES-1:0] lane_clip;

  assign cfg_ready = 1'b1;

  tabl_coef_regs u_coef (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef)
  );

  assign adv2          = !out_valid || m_tready;
  assign adv1          = !s1_valid || adv2;
  assign s_tready      = adv1;
  assign ctrl.load_in  = s_tvalid && adv1;
  assign ctrl.load_out = s1_valid && adv2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv1) begin
        s1_valid <= s_tvalid;
      end
      if (adv2) begin
        out_valid <= s1_valid;
      end
    end
  end

  for (genvar i = 0; i < tabl_pkg::LANES; i++) begin : g_lane
    tabl_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .coef     (coef),
      .sample   (s_tdata[i*tabl_pkg::SAMPLE_W +: tabl_pkg::SAMPLE_W]),
      .filtered (m_tdata[i*tabl_pkg::OUT_W +: tabl_pkg::OUT_W]),
      .clip     (lane_clip[i])
    );
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = |lane_clip;

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !m_tready) |-> !s_tready)
    else $error("stage one would be overwritten");

  a_fill_s1: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> s1_valid)
    else $error("accepted request lost in stage one");

  a_fill_out: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && adv2) |=> out_valid)
    else $error("stage one result did not reach output");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && m_tready && !s1_valid) |=> !out_valid)
    else $error("result repeated on output");

endmodule

`default_nettype wire
